FILE: sv/fconv_pkg.sv
// Shared types and constants for the full linear convolution core.
// No dependencies; imported by every module of the core.
package fconv_pkg;

   localparam int VALUE_W      = 32;
   localparam int SUM_W        = 64;
   localparam int IDX_W        = 4;
   localparam int KLEN_W       = 5;
   localparam int RESULT_LIMIT = 16;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   // per-cycle control broadcast along the row of tap cells
   typedef struct packed {
      logic shift;   // move every sample one cell further
      logic clear;   // zero the delay line (after the last output of a run)
   } cell_ctl_type;

endpackage

FILE: sv/full_linear_convolution_core.sv
// Top level of the full linear convolution core (FIR with tail flush).
// Depends on fconv_pkg, fconv_tap_cell, fconv_sum_tree and fconv_out_fifo.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_ready | cmd, coef_index, value, is_last
//   rsp_    | out       | rsp_valid/rsp_ready | sum, last_of_run
//   csr_    | in        | csr_wr_en           | csr_wr_data = kernel_length
//
// One request transaction per cycle, loads and samples alike, while no flush
// runs and a queue credit is free, taken while earlier results still travel
// or wait at the response side. A sample with is_last then holds req_ready
// low while the kernel_length-1 tail outputs are issued, one per cycle while
// a queue credit is free. Path from sample to response: shift, multiply, one
// register per adder-tree level, queue; the queue credit sets the rate limit.
// Synchronous active-high reset clears the delay line, the queue and
// kernel_length (to 1); coefficients hold garbage until loaded.
module full_linear_convolution_core #(
   parameter int MAX_TAPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [3:0]            req_coef_index,
   input  fconv_pkg::value_type  req_value,
   input  logic                  req_is_last,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fconv_pkg::sum_type    rsp_sum,
   output logic                  rsp_last_of_run,
   // configuration
   input  logic                  csr_wr_en,
   input  logic [4:0]            csr_wr_data
);
   import fconv_pkg::*;

   localparam int LEVELS = $clog2(MAX_TAPS);
   localparam int DEPTH  = 1 << $clog2(LEVELS + 4);   // covers the full round trip
   localparam int CW     = $clog2(DEPTH) + 1;
   localparam int LIM_I  = (MAX_TAPS < RESULT_LIMIT) ? MAX_TAPS : RESULT_LIMIT;
   localparam logic [KLEN_W-1:0] LIM = KLEN_W'(LIM_I);

   // control
   logic [KLEN_W-1:0] taps_ff, taps_in;
   logic              flushing_ff, flushing_in;
   logic [IDX_W-1:0]  flush_left_ff, flush_left_in;
   logic              clear_pend_ff;
   logic [CW-1:0]     outstanding_ff, outstanding_in;
   logic              issue_vld_ff, prod_vld_ff;
   logic              issue_last_ff, prod_last_ff;

   logic         have_room, accept, smp, fl_step, issue, issue_last, pop;
   value_type    shift_value;
   cell_ctl_type ctl;

   // datapath
   value_type sample_w  [MAX_TAPS];
   value_type chain_in  [MAX_TAPS];
   sum_type   product_w [MAX_TAPS];
   logic      tree_vld, tree_last;
   sum_type   tree_sum;

   // ---------------------------------------------------------------- handshake
   // credits: every issued output owns a queue slot until it is popped
   assign have_room = (outstanding_ff < CW'(DEPTH));
   assign req_ready = !flushing_ff && have_room;
   assign accept    = req_valid && req_ready;
   assign smp       = accept && (req_cmd == CMD_SAMPLE);
   assign fl_step   = flushing_ff && have_room;
   assign issue     = smp || fl_step;
   assign pop       = rsp_valid && rsp_ready;

   // a sample is the final output on its own when only one tap is in use
   always_comb begin
      priority if (smp) begin
         issue_last = req_is_last && (taps_ff == KLEN_W'(1));
      end else begin
         issue_last = (flush_left_ff == IDX_W'(1));
      end
   end

   assign shift_value = smp ? req_value : '0;   // tail flush shifts zeros

   // ------------------------------------------------------------ flush control
   always_comb begin
      flushing_in   = flushing_ff;
      flush_left_in = flush_left_ff;
      priority if (smp && req_is_last && (taps_ff > KLEN_W'(1))) begin
         flushing_in   = 1'b1;
         flush_left_in = IDX_W'(taps_ff - KLEN_W'(1));
      end else if (fl_step) begin
         flush_left_in = flush_left_ff - IDX_W'(1);
         flushing_in   = (flush_left_ff != IDX_W'(1));
      end else begin
         flushing_in   = flushing_ff;
      end
   end

   // kernel_length 0 acts as 1, anything above the tap count or RESULT_LIMIT is clamped
   always_comb begin
      taps_in = taps_ff;
      if (csr_wr_en) begin
         priority if (csr_wr_data == '0) begin
            taps_in = KLEN_W'(1);
         end else if (csr_wr_data > LIM) begin
            taps_in = LIM;
         end else begin
            taps_in = csr_wr_data;
         end
      end
   end

   assign outstanding_in = outstanding_ff + CW'(issue) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff        <= KLEN_W'(1);
         flushing_ff    <= 1'b0;
         flush_left_ff  <= '0;
         clear_pend_ff  <= 1'b0;
         outstanding_ff <= '0;
         issue_vld_ff   <= 1'b0;
         prod_vld_ff    <= 1'b0;
      end else begin
         taps_ff        <= taps_in;
         flushing_ff    <= flushing_in;
         flush_left_ff  <= flush_left_in;
         clear_pend_ff  <= issue && issue_last;   // wipe the line in the next cycle
         outstanding_ff <= outstanding_in;
         issue_vld_ff   <= issue;
         prod_vld_ff    <= issue_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      issue_last_ff <= issue_last;
      prod_last_ff  <= issue_last_ff;
   end

   // ------------------------------------------------------------ row of taps
   // products are taken the cycle after the shift, so a coefficient load
   // accepted in that same cycle does not reach the sample ahead of it
   assign ctl.shift = issue;
   assign ctl.clear = clear_pend_ff;

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
      if (k == 0) begin : g_head
         assign chain_in[k] = shift_value;
      end else begin : g_body
         // a shift during the clear leaves only the new sample in the line
         assign chain_in[k] = clear_pend_ff ? '0 : sample_w[k-1];
      end

      fconv_tap_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .sample_in  (chain_in[k]),
         .kern_we    (accept && (req_cmd == CMD_LOAD) && (int'(req_coef_index) == k)),
         .kern_data  (req_value),
         .tap_on     (int'(taps_ff) > k),
         .sample_out (sample_w[k]),
         .product    (product_w[k])
      );
   end

   // ------------------------------------------------------------ sum and queue
   fconv_sum_tree #(
      .MAX_TAPS (MAX_TAPS)
   ) u_tree (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (prod_vld_ff),
      .in_last  (prod_last_ff),
      .product  (product_w),
      .out_vld  (tree_vld),
      .out_last (tree_last),
      .out_sum  (tree_sum)
   );

   fconv_out_fifo #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock           (clock),
      .reset           (reset),
      .push            (tree_vld),
      .push_sum        (tree_sum),
      .push_last       (tree_last),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_sum         (rsp_sum),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // ------------------------------------------------------------ checks
   a_credit_bound : assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= CW'(DEPTH))
      else $error("result credits exceed queue depth");

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      (outstanding_ff == '0) |-> !rsp_valid)
      else $error("response offered with no result outstanding");

   a_flush_count : assert property (@(posedge clock) disable iff (reset)
      (flush_left_ff != '0) |-> flushing_ff)
      else $error("tail counter running outside a flush");

   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      clear_pend_ff |-> !flushing_ff)
      else $error("delay line cleared while the tail is still running");

endmodule

FILE: sv/fconv_tap_cell.sv
// One tap of the delay line: sample register, coefficient and product.
// Depends on fconv_pkg.
module fconv_tap_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  fconv_pkg::cell_ctl_type ctl,
   input  fconv_pkg::value_type sample_in,
   input  logic                 kern_we,
   input  fconv_pkg::value_type kern_data,
   input  logic                 tap_on,
   output fconv_pkg::value_type sample_out,
   output fconv_pkg::sum_type   product
);
   import fconv_pkg::*;

   value_type sample_ff;
   value_type sample_in_w;
   value_type kernel_ff;
   sum_type   product_ff;
   sum_type   product_in;

   always_comb begin
      priority if (ctl.shift) begin
         sample_in_w = sample_in;
      end else if (ctl.clear) begin
         sample_in_w = '0;
      end else begin
         sample_in_w = sample_ff;
      end
   end

   // the neighbour already presents zero when a shift meets a clear
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in_w;
      end
   end

   always_ff @(posedge clock) begin
      if (kern_we) begin
         kernel_ff <= kern_data;
      end
   end

   // signed 32 x 32 product, both operands sign-extended
   always_comb begin
      if (tap_on) begin
         product_in = sum_type'(kernel_ff) * sum_type'(sample_ff);
      end else begin
         product_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign sample_out = sample_ff;
   assign product    = product_ff;

endmodule

FILE: sv/fconv_sum_tree.sv
// Registered binary adder tree over the tap products, with saturation.
// Depends on fconv_pkg.
module fconv_sum_tree #(
   parameter int MAX_TAPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  logic                in_last,
   input  fconv_pkg::sum_type  product [MAX_TAPS],
   output logic                out_vld,
   output logic                out_last,
   output fconv_pkg::sum_type  out_sum
);
   import fconv_pkg::*;

   localparam int LEVELS = $clog2(MAX_TAPS);
   localparam int PAD    = 1 << LEVELS;
   localparam int SW     = SUM_W + LEVELS;

   logic signed [SW-1:0] leaf    [PAD];
   logic signed [SW-1:0] node_ff [1:PAD-1];
   logic [LEVELS-1:0]    vld_ff;
   logic [LEVELS-1:0]    last_ff;
   logic [LEVELS-1:0]    vld_in;
   logic [LEVELS-1:0]    last_in;
   logic [SW-SUM_W:0]    upper;

   for (genvar i = 0; i < PAD; i++) begin : g_leaf
      if (i < MAX_TAPS) begin : g_used
         assign leaf[i] = SW'(product[i]);
      end else begin : g_pad
         assign leaf[i] = '0;
      end
   end

   // heap numbering: node i adds children 2i and 2i+1, leaves sit at PAD..2*PAD-1
   for (genvar i = 1; i < PAD; i++) begin : g_node
      if (2 * i >= PAD) begin : g_bottom
         always_ff @(posedge clock) begin
            node_ff[i] <= leaf[2 * i - PAD] + leaf[2 * i + 1 - PAD];
         end
      end else begin : g_inner
         always_ff @(posedge clock) begin
            node_ff[i] <= node_ff[2 * i] + node_ff[2 * i + 1];
         end
      end
   end

   if (LEVELS > 1) begin : g_line
      assign vld_in  = {vld_ff[LEVELS-2:0], in_vld};
      assign last_in = {last_ff[LEVELS-2:0], in_last};
   end else begin : g_single
      assign vld_in  = in_vld;
      assign last_in = in_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

   // saturate: all bits above the 64-bit sign must agree with it
   assign upper = node_ff[1][SW-1:SUM_W-1];

   always_comb begin
      priority if ((&upper) || !(|upper)) begin
         out_sum = node_ff[1][SUM_W-1:0];
      end else if (node_ff[1][SW-1]) begin
         out_sum = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         out_sum = {1'b0, {(SUM_W-1){1'b1}}};
      end
   end

   assign out_vld  = vld_ff[LEVELS-1];
   assign out_last = last_ff[LEVELS-1];

endmodule

FILE: sv/fconv_out_fifo.sv
// Result queue between the adder tree and the response channel.
// Depends on fconv_pkg; never overflows, the top level holds the credits.
module fconv_out_fifo #(
   parameter int DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fconv_pkg::sum_type push_sum,
   input  logic               push_last,
   input  logic               pop,
   output logic               rsp_valid,
   output fconv_pkg::sum_type rsp_sum,
   output logic               rsp_last_of_run
);
   import fconv_pkg::*;

   localparam int AW = $clog2(DEPTH);

   sum_type       sum_mem  [DEPTH];
   logic          last_mem [DEPTH];
   logic [AW:0]   wr_ptr_ff;
   logic [AW:0]   rd_ptr_ff;
   logic [AW:0]   wr_ptr_in;
   logic [AW:0]   rd_ptr_in;

   assign wr_ptr_in = wr_ptr_ff + (AW + 1)'(push);
   assign rd_ptr_in = rd_ptr_ff + (AW + 1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         sum_mem[wr_ptr_ff[AW-1:0]]  <= push_sum;
         last_mem[wr_ptr_ff[AW-1:0]] <= push_last;
      end
   end

   assign rsp_valid       = (wr_ptr_ff != rd_ptr_ff);
   assign rsp_sum         = sum_mem[rd_ptr_ff[AW-1:0]];
   assign rsp_last_of_run = last_mem[rd_ptr_ff[AW-1:0]];

endmodule
